FILE: sv/spmv_pkg.sv
// ----------------------------------------------------------------------------
// spmv_pkg
// Shared types and constants of the CSR sparse matrix-vector multiply unit.
// ----------------------------------------------------------------------------
`default_nettype none

package spmv_pkg;

   // Field widths
   localparam int INDEX_WIDTH = 12;
   localparam int VALUE_WIDTH = 32;
   localparam int ROW_WIDTH   = 16;
   localparam int LIMIT_WIDTH = 17;
   localparam int ACC_WIDTH   = 64;
   localparam int FRAC_BITS   = 16;

   // Parameter defaults
   localparam int VECTOR_DEPTH_DEFAULT = 4096;
   localparam int MAX_ROWS_DEFAULT     = 65536;

   // Hard ceiling of the row counter (16-bit row index)
   localparam int ROW_CEILING = 65536;

   // Operation codes
   localparam logic [1:0] OP_LOAD    = 2'd0;
   localparam logic [1:0] OP_NONZERO = 2'd1;
   localparam logic [1:0] OP_EMPTY   = 2'd2;
   localparam logic [1:0] OP_UNUSED  = 2'd3;

   typedef struct packed {
      logic [1:0]                    operation;
      logic [INDEX_WIDTH-1:0]        index;
      logic signed [VALUE_WIDTH-1:0] value;
      logic                          row_end;
   } req_type;

   typedef struct packed {
      logic [ROW_WIDTH-1:0]          row_index;
      logic signed [VALUE_WIDTH-1:0] row_sum;
      logic                          saturated;
   } rsp_type;

   // Per-stage control: add a product, close the row
   typedef struct packed {
      logic accumulate;
      logic emit;
   } acc_ctl_type;

endpackage

`default_nettype wire

FILE: sv/spmv_ram.sv
// ----------------------------------------------------------------------------
// spmv_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module spmv_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     write_enable,
   input  wire logic [$clog2(DEPTH)-1:0] write_address,
   input  wire logic [WIDTH-1:0]         write_data,
   input  wire logic                     read_enable,
   input  wire logic [$clog2(DEPTH)-1:0] read_address,
   output logic      [WIDTH-1:0]         read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem_ff[write_address] <= write_data;
      end
      if (read_enable) begin
         read_data_ff <= mem_ff[read_address];
      end
   end

   assign read_data = read_data_ff;

endmodule

`default_nettype wire

FILE: sv/spmv_index_fold.sv
// ----------------------------------------------------------------------------
// spmv_index_fold
// Folds the 12-bit request index into the vector store address range
// (index modulo depth) using a reciprocal multiply and one correction when the depth is below 4096.
// ----------------------------------------------------------------------------
`default_nettype none

module spmv_index_fold #(
   parameter int VECTOR_DEPTH = spmv_pkg::VECTOR_DEPTH_DEFAULT
) (
   input  wire logic [spmv_pkg::INDEX_WIDTH-1:0]   index,
   output logic      [$clog2(VECTOR_DEPTH)-1:0]    address
);

   import spmv_pkg::*;

   localparam int AW = $clog2(VECTOR_DEPTH);

   generate
      if (VECTOR_DEPTH >= (1 << INDEX_WIDTH)) begin : g_direct
         // Every index already lies inside the store
         assign address = AW'(index);
      end else begin : g_fold
         localparam int RecipShift = 2 * INDEX_WIDTH;
         localparam int ScaledWidth = INDEX_WIDTH + RecipShift;
         localparam logic [RecipShift-1:0] RECIP_VALUE =
            RecipShift'((64'd1 << RecipShift) / VECTOR_DEPTH);
         localparam logic [INDEX_WIDTH:0] DEPTH_VALUE = (INDEX_WIDTH + 1)'(VECTOR_DEPTH);

         logic [ScaledWidth-1:0]   scaled;
         logic [INDEX_WIDTH-1:0]   quot;
         logic [RecipShift-1:0]    back;
         logic [INDEX_WIDTH:0]     rem;
         logic [INDEX_WIDTH:0]     fixed;

         // Quotient estimate is exact or one short; remainder is below 2*depth
         always_comb begin
            scaled = ScaledWidth'(index) * ScaledWidth'(RECIP_VALUE);
            quot   = scaled[ScaledWidth-1:RecipShift];
            back   = RecipShift'(quot) * RecipShift'(DEPTH_VALUE);
            rem    = (INDEX_WIDTH + 1)'(RecipShift'(index) - back);
            fixed  = (rem >= DEPTH_VALUE) ? (rem - DEPTH_VALUE) : rem;
         end

         assign address = fixed[AW-1:0];
      end
   endgenerate

endmodule

`default_nettype wire

FILE: sv/spmv_accum.sv
// ----------------------------------------------------------------------------
// spmv_accum
// Saturating 64-bit accumulator, row counter and response register.
// ----------------------------------------------------------------------------
`default_nettype none

module spmv_accum (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  advance,
   input  wire spmv_pkg::acc_ctl_type                 ctl,
   input  wire logic signed [spmv_pkg::ACC_WIDTH-1:0] product,
   input  wire logic [spmv_pkg::LIMIT_WIDTH-1:0]      row_limit,
   input  wire logic                                  rsp_ready,
   output logic                                       rsp_valid,
   output spmv_pkg::rsp_type                          rsp_item
);

   import spmv_pkg::*;

   localparam logic signed [ACC_WIDTH-1:0] ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
   localparam logic signed [ACC_WIDTH-1:0] ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};
   localparam logic signed [VALUE_WIDTH-1:0] SUM_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
   localparam logic signed [VALUE_WIDTH-1:0] SUM_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

   logic signed [ACC_WIDTH-1:0] acc_ff, acc_in;
   logic                        mark_ff, mark_in;
   logic [ROW_WIDTH-1:0]        row_ff, row_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   rsp_type                     rsp_ff, rsp_in;

   logic signed [ACC_WIDTH-1:0] term;
   logic signed [ACC_WIDTH-1:0] sum;
   logic                        ovf_pos, ovf_neg;
   logic signed [ACC_WIDTH-1:0] acc_next;
   logic                        mark_next;
   logic                        fits;
   logic [LIMIT_WIDTH-1:0]      row_inc;

   // Floor-rounded Q16.16 product, saturating add
   always_comb begin
      term      = product >>> FRAC_BITS;
      sum       = acc_ff + term;
      ovf_pos   = !acc_ff[ACC_WIDTH-1] && !term[ACC_WIDTH-1] && sum[ACC_WIDTH-1];
      ovf_neg   = acc_ff[ACC_WIDTH-1] && term[ACC_WIDTH-1] && !sum[ACC_WIDTH-1];
      acc_next  = acc_ff;
      mark_next = mark_ff;
      if (ctl.accumulate) begin
         acc_next  = ovf_pos ? ACC_MAX : (ovf_neg ? ACC_MIN : sum);
         mark_next = mark_ff || ovf_pos || ovf_neg;
      end
   end

   // Row close: clamp to 32 bits, advance the row counter
   always_comb begin
      fits    = (acc_next[ACC_WIDTH-1:VALUE_WIDTH-1] == {(ACC_WIDTH-VALUE_WIDTH+1){1'b0}}) ||
                (acc_next[ACC_WIDTH-1:VALUE_WIDTH-1] == {(ACC_WIDTH-VALUE_WIDTH+1){1'b1}});
      row_inc = LIMIT_WIDTH'(row_ff) + LIMIT_WIDTH'(1);

      acc_in       = acc_ff;
      mark_in      = mark_ff;
      row_in       = row_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      if (advance) begin
         acc_in  = acc_next;
         mark_in = mark_next;
         if (ctl.emit) begin
            rsp_in.row_index = row_ff;
            rsp_in.row_sum   = fits ? acc_next[VALUE_WIDTH-1:0]
                                    : (acc_next[ACC_WIDTH-1] ? SUM_MIN : SUM_MAX);
            rsp_in.saturated = mark_next || !fits;
            rsp_valid_in     = 1'b1;
            acc_in           = '0;
            mark_in          = 1'b0;
            row_in           = (row_inc >= row_limit) ? '0 : row_inc[ROW_WIDTH-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         mark_ff      <= 1'b0;
         row_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         mark_ff      <= mark_in;
         row_ff       <= row_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Response payload
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

`default_nettype wire

FILE: sv/csr_sparse_matrix_vector_multiply_unit.sv
// ----------------------------------------------------------------------------
// csr_sparse_matrix_vector_multiply_unit
// Sparse matrix times dense vector in CSR order, Q16.16 with 64-bit sums.
// ----------------------------------------------------------------------------
// The unit takes one request per clock cycle while it is not held. A load
// request writes one entry of the dense vector store; nonzero requests read
// the store at their column, multiply in Q16.16 and add into a saturating
// 64-bit accumulator; a nonzero with row_end set, or an empty-row request,
// produces one response (row index, sum clamped to 32 bits, saturation flag)
// through the stage-1, stage-2 and response registers. The vector store read
// is registered, with one multiply-accumulate per cycle; the
// pipeline holds only when a finished row reaches the response register while
// the previous response is still not taken. Vector entries never loaded read
// as unknown data; the store has no clearing pass. A load may be followed
// directly by a nonzero that reads the same entry.
`default_nettype none

module csr_sparse_matrix_vector_multiply_unit #(
   parameter int VECTOR_DEPTH = spmv_pkg::VECTOR_DEPTH_DEFAULT,
   parameter int MAX_ROWS     = spmv_pkg::MAX_ROWS_DEFAULT
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire spmv_pkg::req_type                req_item,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output spmv_pkg::rsp_type                     rsp_item,
   input  wire logic                             csr_write_enable,
   input  wire logic [spmv_pkg::LIMIT_WIDTH-1:0] csr_write_data
);

   import spmv_pkg::*;

   localparam int AW = $clog2(VECTOR_DEPTH);
   localparam int RowLimitMax = (MAX_ROWS < ROW_CEILING) ? MAX_ROWS : ROW_CEILING;
   localparam logic [LIMIT_WIDTH-1:0] LIMIT_TOP = LIMIT_WIDTH'(RowLimitMax);

   logic [LIMIT_WIDTH-1:0]        limit_ff, limit_in;
   acc_ctl_type                   s1_ctl_ff, s1_ctl_in;
   logic signed [VALUE_WIDTH-1:0] s1_value_ff;
   acc_ctl_type                   s2_ctl_ff;
   logic signed [ACC_WIDTH-1:0]   s2_product_ff, s2_product_in;

   logic                          advance;
   logic                          req_fire;
   logic [AW-1:0]                 address;
   logic                          ram_we, ram_re;
   logic [VALUE_WIDTH-1:0]        ram_rdata;
   logic signed [VALUE_WIDTH-1:0] vec_value;

   // Row limit register, clamped on write
   always_comb begin
      limit_in = limit_ff;
      if (csr_write_enable) begin
         if (csr_write_data == '0) begin
            limit_in = LIMIT_WIDTH'(1);
         end else if (csr_write_data > LIMIT_TOP) begin
            limit_in = LIMIT_TOP;
         end else begin
            limit_in = csr_write_data;
         end
      end
   end

   // Hold only when a row result meets a full response register
   assign advance   = !(s2_ctl_ff.emit && rsp_valid && !rsp_ready);
   assign req_ready = advance;
   assign req_fire  = req_valid && advance;

   spmv_index_fold #(
      .VECTOR_DEPTH (VECTOR_DEPTH)
   ) u_fold (
      .index   (req_item.index),
      .address (address)
   );

   // Decode request
   always_comb begin
      ram_we    = 1'b0;
      ram_re    = 1'b0;
      s1_ctl_in = '0;
      if (req_fire) begin
         case (req_item.operation)
            OP_LOAD: begin
               ram_we = 1'b1;
            end
            OP_NONZERO: begin
               ram_re               = 1'b1;
               s1_ctl_in.accumulate = 1'b1;
               s1_ctl_in.emit       = req_item.row_end;
            end
            OP_EMPTY: begin
               s1_ctl_in.emit = 1'b1;
            end
            OP_UNUSED: begin
               s1_ctl_in = '0;
            end
            default: begin
               s1_ctl_in = '0;
            end
         endcase
      end
   end

   spmv_ram #(
      .WIDTH (VALUE_WIDTH),
      .DEPTH (VECTOR_DEPTH)
   ) u_store (
      .clock         (clock),
      .write_enable  (ram_we),
      .write_address (address),
      .write_data    (req_item.value),
      .read_enable   (ram_re),
      .read_address  (address),
      .read_data     (ram_rdata)
   );

   // Multiply against the stored vector entry
   assign vec_value     = $signed(ram_rdata);
   assign s2_product_in = ACC_WIDTH'(s1_value_ff) * ACC_WIDTH'(vec_value);

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff  <= LIMIT_TOP;
         s1_ctl_ff <= '0;
         s2_ctl_ff <= '0;
      end else begin
         limit_ff <= limit_in;
         if (advance) begin
            s1_ctl_ff <= s1_ctl_in;
            s2_ctl_ff <= s1_ctl_ff;
         end
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      if (advance) begin
         s1_value_ff   <= req_item.value;
         s2_product_ff <= s2_product_in;
      end
   end

   spmv_accum u_accum (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .ctl       (s2_ctl_ff),
      .product   (s2_product_ff),
      .row_limit (limit_ff),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   // Checks
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid && !rsp_ready))
      else $error("request side held without a blocked response");

   assert property (@(posedge clock) disable iff (reset)
      !(ram_we && ram_re))
      else $error("vector store written and read by one request");

   assert property (@(posedge clock) disable iff (reset)
      (s2_ctl_ff.emit && advance) |=> rsp_valid)
      else $error("finished row did not reach the response register");

   assert property (@(posedge clock) disable iff (reset)
      (limit_ff != '0) && (limit_ff <= LIMIT_TOP))
      else $error("row limit out of range");

endmodule

`default_nettype wire

FILE: tb/sv/csr_sparse_matrix_vector_multiply_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csr_sparse_matrix_vector_multiply_unit_tb
// Drives vector loads, nonzero streams and empty rows into the sparse
// matrix-vector unit with random idling on both channels. Every finished
// row is checked field by field against a typed-in result or an in-bench
// Q16.16 row model. The row limit is changed between phases, and one
// phase holds off the response side long enough to back the unit up.
// ----------------------------------------------------------------------------

module csr_sparse_matrix_vector_multiply_unit_tb;
   import spmv_pkg::*;

   localparam int STORE_DEPTH = VECTOR_DEPTH_DEFAULT;
   localparam int PHASE_ITEMS = 150;
   localparam int HOLD_CYCLES = 300;

   localparam logic signed [63:0] ACC_TOP    = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [63:0] ACC_BOTTOM = 64'sh8000_0000_0000_0000;
   localparam logic signed [63:0] SUM_TOP    = 64'sd2147483647;
   localparam logic signed [63:0] SUM_BOTTOM = -64'sd2147483648;

   localparam rsp_type NO_ROW = '0;

   // Directed table: request, whether the row result is typed in, and the row
   typedef struct packed {
      req_type item;
      logic    typed;
      rsp_type want;
   } stim_row_type;

   localparam int DIRECTED_COUNT = 24;
   localparam stim_row_type DIRECTED [DIRECTED_COUNT] = '{
      // vector entries: +1.0, -1.0 and the extremes
      '{'{OP_LOAD,    12'h000, 32'h0001_0000, 1'b0}, 1'b0, NO_ROW},
      '{'{OP_LOAD,    12'hFFF, 32'h8000_0000, 1'b1}, 1'b0, NO_ROW},
      '{'{OP_LOAD,    12'h001, 32'h7FFF_FFFF, 1'b0}, 1'b0, NO_ROW},
      '{'{OP_LOAD,    12'h002, 32'hFFFF_0000, 1'b0}, 1'b0, NO_ROW},
      // empty row right after reset
      '{'{OP_EMPTY,   12'hFFF, 32'hFFFF_FFFF, 1'b1}, 1'b1,
        '{16'd0, 32'h0000_0000, 1'b0}},
      '{'{OP_NONZERO, 12'h000, 32'h0002_0000, 1'b1}, 1'b1,
        '{16'd1, 32'h0002_0000, 1'b0}},
      // max * max and max * min clamp to 32 bits
      '{'{OP_NONZERO, 12'h001, 32'h7FFF_FFFF, 1'b1}, 1'b1,
        '{16'd2, 32'h7FFF_FFFF, 1'b1}},
      '{'{OP_NONZERO, 12'hFFF, 32'h7FFF_FFFF, 1'b1}, 1'b1,
        '{16'd3, 32'h8000_0000, 1'b1}},
      // unused code is dropped
      '{'{OP_UNUSED,  12'hABC, 32'h1234_5678, 1'b1}, 1'b0, NO_ROW},
      // multi-term row: min * min, then -1.0, then +1.0
      '{'{OP_NONZERO, 12'hFFF, 32'h8000_0000, 1'b0}, 1'b0, NO_ROW},
      '{'{OP_NONZERO, 12'h002, 32'h0001_0000, 1'b0}, 1'b0, NO_ROW},
      '{'{OP_NONZERO, 12'h002, 32'hFFFF_0000, 1'b1}, 1'b0, NO_ROW},
      // rounding toward minus infinity on the smallest step
      '{'{OP_LOAD,    12'h003, 32'h0000_0001, 1'b0}, 1'b0, NO_ROW},
      '{'{OP_NONZERO, 12'h003, 32'hFFFF_FFFF, 1'b1}, 1'b1,
        '{16'd5, 32'hFFFF_FFFF, 1'b0}},
      '{'{OP_NONZERO, 12'h003, 32'h0000_0001, 1'b1}, 1'b1,
        '{16'd6, 32'h0000_0000, 1'b0}},
      // load followed at once by a read of the same entry, then rewritten
      '{'{OP_LOAD,    12'h555, 32'h0003_0000, 1'b0}, 1'b0, NO_ROW},
      '{'{OP_NONZERO, 12'h555, 32'h0001_0000, 1'b0}, 1'b0, NO_ROW},
      '{'{OP_LOAD,    12'h555, 32'hFFFE_0000, 1'b1}, 1'b0, NO_ROW},
      '{'{OP_NONZERO, 12'h555, 32'h0001_0000, 1'b0}, 1'b0, NO_ROW},
      // empty row closes a row that still holds a partial sum
      '{'{OP_EMPTY,   12'h000, 32'h0000_0000, 1'b0}, 1'b0, NO_ROW},
      '{'{OP_EMPTY,   12'h555, 32'h5555_5555, 1'b0}, 1'b1,
        '{16'd8, 32'h0000_0000, 1'b0}},
      '{'{OP_NONZERO, 12'h000, 32'h0000_8000, 1'b1}, 1'b1,
        '{16'd9, 32'h0000_8000, 1'b0}},
      '{'{OP_LOAD,    12'hAAA, 32'h7FFF_FFFF, 1'b0}, 1'b0, NO_ROW},
      '{'{OP_NONZERO, 12'hAAA, 32'h8000_0000, 1'b1}, 1'b0, NO_ROW}
   };

   // Row limits walked by the random phases; the last phase draws its own
   localparam int PHASE_COUNT = 8;
   localparam logic [LIMIT_WIDTH-1:0] LIMIT_PLAN [PHASE_COUNT] = '{
      17'd1, 17'd0, 17'd5, 17'd65536, 17'd131071, 17'd2, 17'd65535, 17'd17
   };
   localparam int HOLD_PHASE = 3;

   logic                   clock            = 1'b0;
   logic                   reset            = 1'b1;
   logic                   req_valid        = 1'b0;
   logic                   req_ready;
   req_type                req_item         = '0;
   logic                   rsp_valid;
   logic                   rsp_ready        = 1'b0;
   rsp_type                rsp_item;
   logic                   csr_write_enable = 1'b0;
   logic [LIMIT_WIDTH-1:0] csr_write_data   = '0;

   // Row model state
   logic [VALUE_WIDTH-1:0]       vec_store [STORE_DEPTH];
   logic signed [ACC_WIDTH-1:0]  row_acc      = '0;
   logic [ROW_WIDTH-1:0]         row_count    = '0;
   logic                         acc_clipped  = 1'b0;
   logic [LIMIT_WIDTH-1:0]       row_cfg      = 17'd65536;

   // Columns that hold a loaded entry; nonzeros only read these
   bit                     col_loaded [STORE_DEPTH];
   int                     loaded_cols [$];

   rsp_type                row_sums_due [$];
   int                     mismatches    = 0;
   bit                     idle_on       = 1'b1;
   bit                     hold_asked    = 1'b0;

   csr_sparse_matrix_vector_multiply_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_item         (req_item),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_item         (rsp_item),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("csr_sparse_matrix_vector_multiply_unit_tb: done, errors");
      $finish;
   end

   // Close the current row: clamp to 32 bits, advance and wrap the row counter
   function automatic rsp_type close_row();
      rsp_type              row;
      logic [LIMIT_WIDTH-1:0] lim;
      logic [LIMIT_WIDTH-1:0] next_row;
      lim = row_cfg;
      if (lim == '0) lim = 17'd1;
      if (lim > 17'd65536) lim = 17'd65536;
      row.row_index = row_count;
      row.saturated = acc_clipped;
      if (row_acc > SUM_TOP) begin
         row.row_sum   = 32'h7FFF_FFFF;
         row.saturated = 1'b1;
      end else if (row_acc < SUM_BOTTOM) begin
         row.row_sum   = 32'h8000_0000;
         row.saturated = 1'b1;
      end else begin
         row.row_sum = row_acc[31:0];
      end
      row_acc     = '0;
      acc_clipped = 1'b0;
      next_row    = {1'b0, row_count} + 17'd1;
      if (next_row >= lim) next_row = '0;
      row_count = next_row[ROW_WIDTH-1:0];
      return row;
   endfunction

   // Apply one accepted request; returns 1 when it finishes a row
   function automatic bit row_step(input req_type it, output rsp_type row);
      logic signed [63:0] full;
      logic signed [63:0] term;
      logic signed [64:0] wide;
      logic [31:0]        entry;
      row = NO_ROW;
      case (it.operation)
         OP_LOAD: begin
            vec_store[it.index] = it.value;
            if (!col_loaded[it.index]) begin
               col_loaded[it.index] = 1'b1;
               loaded_cols.push_back(int'(it.index));
            end
            return 1'b0;
         end
         OP_NONZERO: begin
            entry = vec_store[it.index];
            full  = $signed({{32{it.value[31]}}, it.value}) *
                    $signed({{32{entry[31]}}, entry});
            // Q32.32 -> Q16.16, floor
            term  = full >>> FRAC_BITS;
            wide  = {row_acc[63], row_acc} + {term[63], term};
            if (wide[64] != wide[63]) begin
               row_acc     = wide[64] ? ACC_BOTTOM : ACC_TOP;
               acc_clipped = 1'b1;
            end else begin
               row_acc = wide[63:0];
            end
            if (it.row_end) begin
               row = close_row();
               return 1'b1;
            end
            return 1'b0;
         end
         OP_EMPTY: begin
            row = close_row();
            return 1'b1;
         end
         default: return 1'b0;
      endcase
   endfunction

   // Mix of small Q16.16 values, full-range words and the extremes
   function automatic logic [31:0] rand_fixed();
      logic [31:0] v;
      case ($urandom_range(7))
         0, 1: v = $urandom;
         2: begin
            case ($urandom_range(4))
               0: v = 32'h7FFF_FFFF;
               1: v = 32'h8000_0000;
               2: v = 32'h0000_0001;
               3: v = 32'hFFFF_FFFF;
               default: v = 32'h0000_0000;
            endcase
         end
         default: v = 32'($urandom_range(1 << 20)) - 32'(1 << 19);
      endcase
      return v;
   endfunction

   // Present one request, wait for the handshake, log its row result.
   // Entered and left at a falling edge.
   task automatic push_request(input req_type it, input bit typed, input rsp_type want);
      rsp_type row;
      while (idle_on && $urandom_range(99) < 19) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_item  <= it;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      if (row_step(it, row)) row_sums_due.push_back(typed ? want : row);
      @(negedge clock);
   endtask

   // Write the row limit once the unit has drained
   task automatic set_row_limit(input logic [LIMIT_WIDTH-1:0] rows);
      req_valid <= 1'b0;
      while (row_sums_due.size() != 0) @(negedge clock);
      // trailing loads may still be in flight
      repeat (8) @(negedge clock);
      csr_write_data   <= rows;
      csr_write_enable <= 1'b1;
      row_cfg = rows;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Random traffic: mostly well-formed rows over loaded columns
   task automatic run_phase(input int quota);
      int      counted;
      int      pick;
      int      len;
      bit      broken;
      req_type it;
      counted = 0;
      while (counted < quota) begin
         pick        = $urandom_range(99);
         it.index    = 12'($urandom_range(STORE_DEPTH - 1));
         it.value    = rand_fixed();
         it.row_end  = 1'($urandom_range(1));
         if (loaded_cols.size() < 24 || pick < 10) begin
            it.operation = OP_LOAD;
            push_request(it, 1'b0, NO_ROW);
            counted++;
         end else if (pick < 13) begin
            it.operation = OP_UNUSED;
            push_request(it, 1'b0, NO_ROW);
         end else if (pick < 18) begin
            it.operation = OP_EMPTY;
            push_request(it, 1'b0, NO_ROW);
            counted++;
         end else begin
            len    = $urandom_range(8, 1);
            // some rows end with an empty-row request instead of row_end
            broken = (pick < 26);
            for (int k = 0; k < len; k++) begin
               it.operation = OP_NONZERO;
               it.index     = 12'(loaded_cols[$urandom_range(loaded_cols.size() - 1)]);
               it.value     = rand_fixed();
               it.row_end   = (k == len - 1) && !broken;
               push_request(it, 1'b0, NO_ROW);
               counted++;
            end
            if (broken) begin
               it.operation = OP_EMPTY;
               it.row_end   = 1'($urandom_range(1));
               push_request(it, 1'b0, NO_ROW);
               counted++;
            end
         end
      end
   endtask

   // Request side
   initial begin : stimulus
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int i = 0; i < DIRECTED_COUNT; i++) begin
         push_request(DIRECTED[i].item, DIRECTED[i].typed, DIRECTED[i].want);
      end

      for (int p = 0; p < PHASE_COUNT; p++) begin
         if (p == PHASE_COUNT - 1) set_row_limit(17'($urandom_range(40, 1)));
         else set_row_limit(LIMIT_PLAN[p]);
         idle_on = (p != HOLD_PHASE);
         if (p == HOLD_PHASE) hold_asked = 1'b1;
         run_phase(PHASE_ITEMS);
      end
      req_valid <= 1'b0;
      idle_on = 1'b1;

      while (row_sums_due.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      if (mismatches == 0) begin
         $display("csr_sparse_matrix_vector_multiply_unit_tb: done, clean");
      end else begin
         $display("csr_sparse_matrix_vector_multiply_unit_tb: done, errors");
      end
      $finish;
   end

   // Response side: random back-pressure, plus one long hold-off on request
   initial begin : result_sink
      forever begin
         @(negedge clock);
         if (hold_asked) begin
            hold_asked = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         rsp_ready <= !(idle_on && $urandom_range(99) < 19);
      end
   end

   // Row result check
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (row_sums_due.size() == 0) begin
            $display("%0t: row result with none expected: row %0d sum %h sat %b",
                     $time, rsp_item.row_index, rsp_item.row_sum, rsp_item.saturated);
            mismatches++;
         end else begin
            want = row_sums_due.pop_front();
            if (rsp_item.row_index !== want.row_index) begin
               $display("%0t: row_index expected %0d, got %0d",
                        $time, want.row_index, rsp_item.row_index);
               mismatches++;
            end
            if (rsp_item.row_sum !== want.row_sum) begin
               $display("%0t: row %0d row_sum expected %h, got %h",
                        $time, want.row_index, want.row_sum, rsp_item.row_sum);
               mismatches++;
            end
            if (rsp_item.saturated !== want.saturated) begin
               $display("%0t: row %0d saturated expected %b, got %b",
                        $time, want.row_index, want.saturated, rsp_item.saturated);
               mismatches++;
            end
         end
      end
   end

endmodule

FILE: sim.f
sv/spmv_pkg.sv
sv/spmv_ram.sv
sv/spmv_index_fold.sv
sv/spmv_accum.sv
sv/csr_sparse_matrix_vector_multiply_unit.sv
tb/sv/csr_sparse_matrix_vector_multiply_unit_tb.sv
